### rtl/gpcb_pkg.sv
// ----------------------------------------------------------------------------
// gpcb_pkg: shared widths for the cube-to-ball grid point map
// Field widths of the item channels, the divisions register and the
// fixed intermediate widths of the front stages.
// ----------------------------------------------------------------------------
package gpcb_pkg;

    localparam int AXES    = 3;
    localparam int IDX_W   = 8;   // grid index
    localparam int DIV_W   = 8;   // divisions register
    localparam int COORD_W = 16;  // signed output coordinate
    localparam int VNUM_W  = 24;  // linear vertex number
    localparam int SQ_W    = 16;  // square of an 8-bit magnitude
    localparam int SUM_W   = 18;  // sum of three squares
    localparam int K_W     = 34;  // n^2 * sum of squares
    localparam int R_W     = 32;  // a^2 * M^2

endpackage

### rtl/gpcb_in_if.sv
// ----------------------------------------------------------------------------
// gpcb_in_if: grid point item channel
// Valid/ready channel that carries one grid index triple per item.
// ----------------------------------------------------------------------------
interface gpcb_in_if;

    logic                       valid;
    logic                       ready;
    logic [gpcb_pkg::IDX_W-1:0] index_x;
    logic [gpcb_pkg::IDX_W-1:0] index_y;
    logic [gpcb_pkg::IDX_W-1:0] index_z;

    modport source (output valid, output index_x, output index_y, output index_z,
                    input ready);
    modport sink   (input valid, input index_x, input index_y, input index_z,
                    output ready);

endinterface

### rtl/gpcb_out_if.sv
// ----------------------------------------------------------------------------
// gpcb_out_if: mapped point item channel
// Valid/ready channel that carries the ball coordinates and vertex number.
// ----------------------------------------------------------------------------
interface gpcb_out_if;

    logic                                valid;
    logic                                ready;
    logic signed [gpcb_pkg::COORD_W-1:0] coord_x;
    logic signed [gpcb_pkg::COORD_W-1:0] coord_y;
    logic signed [gpcb_pkg::COORD_W-1:0] coord_z;
    logic        [gpcb_pkg::VNUM_W-1:0]  vertex_number;

    modport source (output valid, output coord_x, output coord_y, output coord_z,
                    output vertex_number, input ready);
    modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                    input vertex_number, output ready);

endinterface

### rtl/grid_point_cube_to_ball_map.sv
// ----------------------------------------------------------------------------
// grid_point_cube_to_ball_map: map cube grid points onto the unit ball
// Clamps the indices, forms a = 2i - n per axis, and finds each rounded
// coordinate |a|*M/(n*sqrt(S)) one result bit per pipeline stage.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one grid point (index_x, index_y, index_z) per item.
//   out_ch carries coord_x/y/z (signed, FRAC_BITS fraction bits) and the
//   linear vertex number, one result item per input item, in order.
//   cfg_wr_en/cfg_wr_data write grid_divisions; change it only while idle.
// Throughput: one item per cycle while out_ch is not stalled. Pipeline:
//   four front stages (clamp, squares, sums, products), one stage per
//   coordinate bit of the restoring search (FRAC_BITS + 1) and the
//   output register.
// Reset: all valid bits clear, grid_divisions returns to 1.
// Stall: while a result waits and out_ch.ready is low, the whole pipeline
//   holds and in_ch.ready drops; an empty output register lets it advance.
// ----------------------------------------------------------------------------
module grid_point_cube_to_ball_map #(
    parameter int MAX_DIVISIONS = 255,
    parameter int FRAC_BITS     = 14
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [gpcb_pkg::DIV_W-1:0] cfg_wr_data,
    gpcb_in_if.sink                    in_ch,
    gpcb_out_if.source                 out_ch
);

    localparam int NMAX = (MAX_DIVISIONS > 255) ? 255 : MAX_DIVISIONS;
    localparam int NS   = FRAC_BITS + 1;                       // search stages
    localparam int YW   = FRAC_BITS + 2;                       // y = 2q
    localparam int WA   = 2 * FRAC_BITS + 5 + gpcb_pkg::K_W;   // accumulators
    localparam int QW   = FRAC_BITS + 1;

    localparam logic [gpcb_pkg::DIV_W-1:0] NMAX_V = gpcb_pkg::DIV_W'(NMAX);

    localparam int IW = gpcb_pkg::IDX_W;
    localparam int AX = gpcb_pkg::AXES;

    logic en;
    logic [gpcb_pkg::DIV_W-1:0] div_reg;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg <= gpcb_pkg::DIV_W'(1);
        end
        else if (cfg_wr_en)
        begin
            div_reg <= cfg_wr_data;
        end
    end

    // Advance everything when the output register is free or being taken
    assign en          = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = en;

    // ------------------------------------------------------------------
    // Stage 1: clamp, offset a = 2i - n, magnitude and sign
    // ------------------------------------------------------------------
    logic [IW-1:0] n_eff;
    logic [IW-1:0] idx_in   [AX];
    logic [IW-1:0] idx_cl   [AX];
    logic [IW-1:0] ua_next  [AX];
    logic          neg_next [AX];

    logic          v1_reg;
    logic [IW-1:0] n1_n_reg;
    logic [IW-1:0] s1_idx_reg [AX];
    logic [IW-1:0] s1_ua_reg  [AX];
    logic          s1_neg_reg [AX];

    assign idx_in[0] = in_ch.index_x;
    assign idx_in[1] = in_ch.index_y;
    assign idx_in[2] = in_ch.index_z;

    always_comb
    begin
        logic [IW:0] two_i;
        logic [IW:0] nn;
        logic [IW:0] diff;
        n_eff = (div_reg == '0) ? IW'(1) : div_reg;
        if (n_eff > NMAX_V)
        begin
            n_eff = NMAX_V;
        end
        for (int k = 0; k < AX; k++)
        begin
            idx_cl[k]   = (idx_in[k] > n_eff) ? n_eff : idx_in[k];
            two_i       = {idx_cl[k], 1'b0};
            nn          = {1'b0, n_eff};
            neg_next[k] = two_i < nn;
            diff        = neg_next[k] ? (nn - two_i) : (two_i - nn);
            ua_next[k]  = diff[IW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_n_reg <= n_eff;
            for (int k = 0; k < AX; k++)
            begin
                s1_idx_reg[k] <= idx_cl[k];
                s1_ua_reg[k]  <= ua_next[k];
                s1_neg_reg[k] <= neg_next[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: squares, max-norm, n + 1
    // ------------------------------------------------------------------
    logic                         v2_reg;
    logic [gpcb_pkg::SQ_W-1:0]    s2_asq_reg [AX];
    logic [IW-1:0]                s2_m_reg;
    logic [IW-1:0]                s2_n_reg;
    logic [IW:0]                  s2_n1_reg;
    logic [IW-1:0]                s2_idx_reg [AX];
    logic                         s2_neg_reg [AX];
    logic [IW-1:0]                m_next;

    always_comb
    begin
        m_next = s1_ua_reg[0];
        for (int k = 1; k < AX; k++)
        begin
            if (s1_ua_reg[k] > m_next)
            begin
                m_next = s1_ua_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_m_reg  <= m_next;
            s2_n_reg  <= n1_n_reg;
            s2_n1_reg <= {1'b0, n1_n_reg} + (IW+1)'(1);
            for (int k = 0; k < AX; k++)
            begin
                s2_asq_reg[k] <= gpcb_pkg::SQ_W'(s1_ua_reg[k]) * gpcb_pkg::SQ_W'(s1_ua_reg[k]);
                s2_idx_reg[k] <= s1_idx_reg[k];
                s2_neg_reg[k] <= s1_neg_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: sum of squares, M^2, n^2, partial vertex number
    // ------------------------------------------------------------------
    logic                         v3_reg;
    logic [gpcb_pkg::SUM_W-1:0]   s3_s_reg;
    logic [gpcb_pkg::SQ_W-1:0]    s3_msq_reg;
    logic [gpcb_pkg::SQ_W-1:0]    s3_nsq_reg;
    logic [gpcb_pkg::SQ_W-1:0]    s3_asq_reg [AX];
    logic                         s3_neg_reg [AX];
    logic                         s3_zero_reg [AX];
    logic [15:0]                  s3_vpart_reg;
    logic [IW+8:0]                s3_n1sq_reg;
    logic [IW-1:0]                s3_iz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_s_reg     <= gpcb_pkg::SUM_W'(s2_asq_reg[0]) + gpcb_pkg::SUM_W'(s2_asq_reg[1])
                          + gpcb_pkg::SUM_W'(s2_asq_reg[2]);
            s3_msq_reg   <= gpcb_pkg::SQ_W'(s2_m_reg) * gpcb_pkg::SQ_W'(s2_m_reg);
            s3_nsq_reg   <= gpcb_pkg::SQ_W'(s2_n_reg) * gpcb_pkg::SQ_W'(s2_n_reg);
            s3_vpart_reg <= 16'(s2_idx_reg[1]) * 16'(s2_n1_reg) + 16'(s2_idx_reg[0]);
            s3_n1sq_reg  <= (IW+9)'(s2_n1_reg) * (IW+9)'(s2_n1_reg);
            s3_iz_reg    <= s2_idx_reg[2];
            for (int k = 0; k < AX; k++)
            begin
                s3_asq_reg[k]  <= s2_asq_reg[k];
                s3_neg_reg[k]  <= s2_neg_reg[k];
                s3_zero_reg[k] <= (s2_asq_reg[k] == '0);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: K = n^2 * S, R = a^2 * M^2, vertex number
    // ------------------------------------------------------------------
    logic                          v4_reg;
    logic [gpcb_pkg::K_W-1:0]      s4_k_reg;
    logic [gpcb_pkg::R_W-1:0]      s4_r_reg [AX];
    logic                          s4_neg_reg [AX];
    logic                          s4_zero_reg [AX];
    logic [gpcb_pkg::VNUM_W-1:0]   s4_vnum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_k_reg    <= gpcb_pkg::K_W'(s3_nsq_reg) * gpcb_pkg::K_W'(s3_s_reg);
            s4_vnum_reg <= gpcb_pkg::VNUM_W'(s3_iz_reg) * gpcb_pkg::VNUM_W'(s3_n1sq_reg)
                         + gpcb_pkg::VNUM_W'(s3_vpart_reg);
            for (int k = 0; k < AX; k++)
            begin
                s4_r_reg[k]    <= gpcb_pkg::R_W'(s3_asq_reg[k]) * gpcb_pkg::R_W'(s3_msq_reg);
                s4_neg_reg[k]  <= s3_neg_reg[k];
                s4_zero_reg[k] <= s3_zero_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Search stages: one bit of q per stage, MSB first.
    // With y = 2q, x = y - 1: keep A = y^2*K and B = y*K, and accept a
    // trial bit when A + K <= R + 2B, i.e. (2q-1)^2*K <= R.
    // ------------------------------------------------------------------
    logic                         sv_reg   [1:NS];
    logic [WA-1:0]                sa_reg   [1:NS][AX];
    logic [WA-1:0]                sb_reg   [1:NS][AX];
    logic [YW-1:0]                sy_reg   [1:NS][AX];
    logic [WA-1:0]                sr_reg   [1:NS][AX];
    logic                         sn_reg   [1:NS][AX];
    logic                         sz_reg   [1:NS][AX];
    logic [gpcb_pkg::K_W-1:0]     sk_reg   [1:NS];
    logic [gpcb_pkg::VNUM_W-1:0]  svn_reg  [1:NS];

    for (genvar s = 0; s < NS; s++)
    begin : g_search
        localparam int J = FRAC_BITS - s;

        logic                        cur_v;
        logic [gpcb_pkg::K_W-1:0]    cur_k;
        logic [gpcb_pkg::VNUM_W-1:0] cur_vn;
        logic [WA-1:0]               cur_a [AX];
        logic [WA-1:0]               cur_b [AX];
        logic [YW-1:0]               cur_y [AX];
        logic [WA-1:0]               cur_r [AX];
        logic                        cur_n [AX];
        logic                        cur_z [AX];
        logic [WA-1:0]               nxt_a [AX];
        logic [WA-1:0]               nxt_b [AX];
        logic [YW-1:0]               nxt_y [AX];

        // Select this stage's source: the front stages or the previous bit
        always_comb
        begin
            if (s == 0)
            begin
                cur_v  = v4_reg;
                cur_k  = s4_k_reg;
                cur_vn = s4_vnum_reg;
                for (int k = 0; k < AX; k++)
                begin
                    cur_a[k] = '0;
                    cur_b[k] = '0;
                    cur_y[k] = '0;
                    cur_r[k] = WA'(s4_r_reg[k]) << (2 * FRAC_BITS + 2);
                    cur_n[k] = s4_neg_reg[k];
                    cur_z[k] = s4_zero_reg[k];
                end
            end
            else
            begin
                cur_v  = sv_reg[(s == 0) ? 1 : s];
                cur_k  = sk_reg[(s == 0) ? 1 : s];
                cur_vn = svn_reg[(s == 0) ? 1 : s];
                for (int k = 0; k < AX; k++)
                begin
                    cur_a[k] = sa_reg[(s == 0) ? 1 : s][k];
                    cur_b[k] = sb_reg[(s == 0) ? 1 : s][k];
                    cur_y[k] = sy_reg[(s == 0) ? 1 : s][k];
                    cur_r[k] = sr_reg[(s == 0) ? 1 : s][k];
                    cur_n[k] = sn_reg[(s == 0) ? 1 : s][k];
                    cur_z[k] = sz_reg[(s == 0) ? 1 : s][k];
                end
            end
        end

        // Try setting bit J of q
        always_comb
        begin
            logic [WA-1:0] ke;
            logic [WA-1:0] bt;
            logic [WA-1:0] at;
            ke = WA'(cur_k);
            for (int k = 0; k < AX; k++)
            begin
                bt = cur_b[k] + (ke << (J + 1));
                at = cur_a[k] + (cur_b[k] << (J + 2)) + (ke << (2 * J + 2));
                if ((at + ke) <= (cur_r[k] + (bt << 1)))
                begin
                    nxt_a[k] = at;
                    nxt_b[k] = bt;
                    nxt_y[k] = cur_y[k] | (YW'(1) << (J + 1));
                end
                else
                begin
                    nxt_a[k] = cur_a[k];
                    nxt_b[k] = cur_b[k];
                    nxt_y[k] = cur_y[k];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sv_reg[s + 1] <= 1'b0;
            end
            else if (en)
            begin
                sv_reg[s + 1] <= cur_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sk_reg[s + 1]  <= cur_k;
                svn_reg[s + 1] <= cur_vn;
                for (int k = 0; k < AX; k++)
                begin
                    sa_reg[s + 1][k] <= nxt_a[k];
                    sb_reg[s + 1][k] <= nxt_b[k];
                    sy_reg[s + 1][k] <= nxt_y[k];
                    sr_reg[s + 1][k] <= cur_r[k];
                    sn_reg[s + 1][k] <= cur_n[k];
                    sz_reg[s + 1][k] <= cur_z[k];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: apply sign, force zero axes, saturate to 16 bits
    // ------------------------------------------------------------------
    logic                                out_valid_reg;
    logic signed [gpcb_pkg::COORD_W-1:0] coord_next [AX];
    logic signed [gpcb_pkg::COORD_W-1:0] coord_reg  [AX];
    logic        [gpcb_pkg::VNUM_W-1:0]  vnum_reg;

    always_comb
    begin
        logic [QW-1:0]      q;
        logic signed [QW+1:0] sv;
        for (int k = 0; k < AX; k++)
        begin
            q  = sy_reg[NS][k][YW-1:1];
            if (sz_reg[NS][k])
            begin
                q = '0;
            end
            sv = sn_reg[NS][k] ? -$signed({2'b00, q}) : $signed({2'b00, q});
            if (sv > (QW+2)'(32767))
            begin
                coord_next[k] = 16'sh7FFF;
            end
            else if (sv < -$signed((QW+2)'(32768)))
            begin
                coord_next[k] = 16'sh8000;
            end
            else
            begin
                coord_next[k] = gpcb_pkg::COORD_W'(sv);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= sv_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vnum_reg <= svn_reg[NS];
            for (int k = 0; k < AX; k++)
            begin
                coord_reg[k] <= coord_next[k];
            end
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.coord_x       = coord_reg[0];
    assign out_ch.coord_y       = coord_reg[1];
    assign out_ch.coord_z       = coord_reg[2];
    assign out_ch.vertex_number = vnum_reg;

endmodule

### rtl/gpcb_check.sv
// ----------------------------------------------------------------------------
// gpcb_check: port-level checks for the cube-to-ball grid point map
// Watches the top level's channels and is attached to it by bind.
// ----------------------------------------------------------------------------
module gpcb_check #(
    parameter int FRAC_BITS = 14
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [gpcb_pkg::COORD_W-1:0] coord_x,
    input logic signed [gpcb_pkg::COORD_W-1:0] coord_y,
    input logic signed [gpcb_pkg::COORD_W-1:0] coord_z,
    input logic        [gpcb_pkg::VNUM_W-1:0]  vertex_number
);

    localparam int ONE     = 2 ** FRAC_BITS;
    localparam int LIM_POS = (ONE > 32767) ? 32767 : ONE;
    localparam int LIM_NEG = (ONE > 32768) ? 32768 : ONE;

    // Hold a stalled result
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(coord_x) && $stable(coord_y)
            && $stable(coord_z) && $stable(vertex_number))
        else $error("stalled result item changed");

    // An empty output register always frees the input
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    // Each coordinate lies within the unit range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (int'(coord_x) <= LIM_POS) && (int'(coord_x) >= -LIM_NEG)
            && (int'(coord_y) <= LIM_POS) && (int'(coord_y) >= -LIM_NEG)
            && (int'(coord_z) <= LIM_POS) && (int'(coord_z) >= -LIM_NEG))
        else $error("coordinate outside unit range");

    // No result right after reset
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result item present after reset");

endmodule

bind grid_point_cube_to_ball_map gpcb_check #(.FRAC_BITS(FRAC_BITS)) u_gpcb_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .coord_x       (out_ch.coord_x),
    .coord_y       (out_ch.coord_y),
    .coord_z       (out_ch.coord_z),
    .vertex_number (out_ch.vertex_number)
);

### tb/tb_grid_point_cube_to_ball_map.sv
// ----------------------------------------------------------------------------
// tb_grid_point_cube_to_ball_map: self-checking bench for the cube-to-ball map
// Streams grid points through several divisions settings, predicts each
// mapped point with an exact integer search, and checks results in order
// under random source bursts and random sink stalls.
// ----------------------------------------------------------------------------
module tb_grid_point_cube_to_ball_map;

    localparam int FRAC     = 14;
    localparam int MAX_DIV  = 255;
    localparam int LATENCY  = FRAC + 6;

    typedef struct packed {
        logic [gpcb_pkg::IDX_W-1:0] ix;
        logic [gpcb_pkg::IDX_W-1:0] iy;
        logic [gpcb_pkg::IDX_W-1:0] iz;
    } point_t;

    typedef struct packed {
        logic signed [gpcb_pkg::COORD_W-1:0] cx;
        logic signed [gpcb_pkg::COORD_W-1:0] cy;
        logic signed [gpcb_pkg::COORD_W-1:0] cz;
        logic [gpcb_pkg::VNUM_W-1:0]         vnum;
    } mapped_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_wr_en;
    logic [gpcb_pkg::DIV_W-1:0] cfg_wr_data;

    gpcb_in_if  in_ch ();
    gpcb_out_if out_ch ();

    grid_point_cube_to_ball_map #(.MAX_DIVISIONS(MAX_DIV), .FRAC_BITS(FRAC)) uut (
        .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    point_t  pending_points[$];
    mapped_t expected_points[$];
    logic [gpcb_pkg::DIV_W-1:0] divs_setting;
    int      mismatches = 0;
    int      points_sent = 0;
    int      points_checked = 0;
    int      burst_left;
    int      gap_left;
    int      stall_phase;
    bit      driver_enable;

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Rounded magnitude of one coordinate: largest q with (2q-1)^2 n^2 S <= 4 a^2 M^2 4^F
    function automatic longint unsigned axis_magnitude(longint unsigned ua,
        longint unsigned m, longint unsigned s, longint unsigned n);
        logic [127:0] rhs;
        logic [127:0] lhs;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        lo = 0;
        hi = 64'd1 << FRAC;
        if (s == 0 || ua == 0)
            return 0;
        rhs = 128'd4 * ua * ua * m * m * (128'd1 << (2 * FRAC));
        while (lo < hi)
        begin
            mid = lo + (hi - lo + 1) / 2;
            lhs = 128'(2 * mid - 1) * (2 * mid - 1) * n * n * s;
            if (lhs <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    // Map one point with the current divisions setting
    function automatic mapped_t map_point(point_t p, logic [gpcb_pkg::DIV_W-1:0] divs);
        longint unsigned n;
        longint unsigned idx[3];
        longint signed   a[3];
        longint unsigned ua[3];
        longint unsigned m;
        longint unsigned s;
        longint signed   v[3];
        mapped_t r;
        n = (divs == 0) ? 1 : divs;
        if (n > MAX_DIV)
            n = MAX_DIV;
        idx[0] = p.ix;
        idx[1] = p.iy;
        idx[2] = p.iz;
        m = 0;
        s = 0;
        for (int k = 0; k < 3; k++)
        begin
            if (idx[k] > n)
                idx[k] = n;
            a[k]  = 2 * longint'(idx[k]) - longint'(n);
            ua[k] = (a[k] < 0) ? -a[k] : a[k];
            if (ua[k] > m)
                m = ua[k];
            s += ua[k] * ua[k];
        end
        for (int k = 0; k < 3; k++)
        begin
            v[k] = longint'(axis_magnitude(ua[k], m, s, n));
            if (a[k] < 0)
                v[k] = -v[k];
            if (v[k] > 32767)
                v[k] = 32767;
            if (v[k] < -32768)
                v[k] = -32768;
        end
        r.cx   = v[0][gpcb_pkg::COORD_W-1:0];
        r.cy   = v[1][gpcb_pkg::COORD_W-1:0];
        r.cz   = v[2][gpcb_pkg::COORD_W-1:0];
        r.vnum = gpcb_pkg::VNUM_W'(idx[2] * (n + 1) * (n + 1) + idx[1] * (n + 1) + idx[0]);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Driver: bursts of items with random gaps between them
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid   <= 1'b0;
            in_ch.index_x <= '0;
            in_ch.index_y <= '0;
            in_ch.index_z <= '0;
            burst_left    <= 0;
            gap_left      <= 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                expected_points.push_back(map_point({in_ch.index_x, in_ch.index_y,
                                                     in_ch.index_z}, divs_setting));
                points_sent++;
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (driver_enable && pending_points.size() > 0 && gap_left == 0)
                begin
                    point_t p;
                    p = pending_points.pop_front();
                    in_ch.valid   <= 1'b1;
                    in_ch.index_x <= p.ix;
                    in_ch.index_y <= p.iy;
                    in_ch.index_z <= p.iz;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left <= gap_left - 1;
                end
            end
        end
    end

    // Receiver: stall pattern that shifts between free running and heavy stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_phase  <= 0;
        end
        else
        begin
            stall_phase <= (stall_phase + 1) % 300;
            if (stall_phase < 100)
                out_ch.ready <= 1'b1;
            else if (stall_phase < 200)
                out_ch.ready <= ($urandom_range(0, 3) != 0);
            else
                out_ch.ready <= ($urandom_range(0, 2) == 0);
        end
    end

    // Monitor: compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_points.size() == 0)
            begin
                report_mismatch("unexpected result item", out_ch.vertex_number, -1);
            end
            else
            begin
                mapped_t w;
                w = expected_points.pop_front();
                if (out_ch.coord_x !== w.cx)
                    report_mismatch("coord_x", out_ch.coord_x, w.cx);
                if (out_ch.coord_y !== w.cy)
                    report_mismatch("coord_y", out_ch.coord_y, w.cy);
                if (out_ch.coord_z !== w.cz)
                    report_mismatch("coord_z", out_ch.coord_z, w.cz);
                if (out_ch.vertex_number !== w.vnum)
                    report_mismatch("vertex_number", out_ch.vertex_number, w.vnum);
                points_checked++;
            end
        end
    end

    task automatic add_point(int x, int y, int z);
        point_t p;
        p.ix = gpcb_pkg::IDX_W'(x);
        p.iy = gpcb_pkg::IDX_W'(y);
        p.iz = gpcb_pkg::IDX_W'(z);
        pending_points.push_back(p);
    endtask

    // Hold until every queued item is accepted and every result checked
    task automatic drain();
        while (pending_points.size() > 0 || in_ch.valid || expected_points.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_divisions(logic [gpcb_pkg::DIV_W-1:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        divs_setting = value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Random phase: mostly in-grid points, some past the grid edge
    task automatic random_points(int count, int n);
        int lim;
        for (int i = 0; i < count; i++)
        begin
            lim = ($urandom_range(0, 4) == 0) ? 255 : n;
            add_point(int'($urandom_range(0, lim)), int'($urandom_range(0, lim)),
                      int'($urandom_range(0, lim)));
        end
    endtask

    int div_list[] = '{1, 0, 255, 2, 7, 128, 37, 254};

    // Stimulus
    initial
    begin
        driver_enable = 1'b0;
        divs_setting  = 1;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        rst_n         = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset setting, corners and out-of-grid indices
        driver_enable = 1'b1;
        add_point(0, 0, 0);
        add_point(1, 1, 1);
        add_point(255, 0, 255);
        add_point(1, 0, 0);
        drain();

        foreach (div_list[d])
        begin
            int n;
            write_divisions(gpcb_pkg::DIV_W'(div_list[d]));
            n = (div_list[d] == 0) ? 1 : div_list[d];
            // Directed: center, corners, faces, clamping, all-ones bits
            add_point(n / 2, n / 2, n / 2);
            add_point(0, 0, 0);
            add_point(n, n, n);
            add_point(n, 0, n / 2);
            add_point(255, 255, 255);
            add_point(170, 85, 255);
            add_point(0, n, 0);
            random_points(140, n);
            drain();
        end

        $display("Checked %0d of %0d mapped points over %0d divisions settings.",
                 points_checked, points_sent, div_list.size() + 1);
        if (mismatches == 0)
            $display("tb_grid_point_cube_to_ball_map passed");
        else
            $display("tb_grid_point_cube_to_ball_map failed");
        $finish;
    end

    // Timeout
    initial
    begin
        #2000000;
        $display("tb_grid_point_cube_to_ball_map failed");
        $finish;
    end

endmodule
